@@ hdl/adjmg_pkg.sv @@
// Types and codes shared by the adjacency-matrix graph table.
// Holds the word structs, token and command structs, and the op/status codes.
package adjmg_pkg;

  localparam int unsigned SLOT_W = 10;

  localparam logic [2:0] FN_ADD_V  = 3'd0;
  localparam logic [2:0] FN_DEL_V  = 3'd1;
  localparam logic [2:0] FN_ADD_E  = 3'd2;
  localparam logic [2:0] FN_DEL_E  = 3'd3;
  localparam logic [2:0] FN_QUERY  = 3'd4;

  localparam logic [2:0] STAT_DONE   = 3'd0;
  localparam logic [2:0] STAT_EXISTS = 3'd1;
  localparam logic [2:0] STAT_NONE   = 3'd2;
  localparam logic [2:0] STAT_MAX    = 3'd3;
  localparam logic [2:0] STAT_FULL   = 3'd4;

  localparam logic [1:0] CMD_ADD_V = 2'd0;
  localparam logic [1:0] CMD_DEL_V = 2'd1;
  localparam logic [1:0] CMD_SET_E = 2'd2;
  localparam logic [1:0] CMD_CLR_E = 2'd3;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] vertex_a;
    logic signed [31:0] vertex_b;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [30:0] max_neighbour;
  } out_word_t;

  typedef struct packed {
    logic              vld;
    logic              found_a;
    logic [SLOT_W-1:0] slot_a;
    logic              found_b;
    logic [SLOT_W-1:0] slot_b;
    logic              free_ok;
    logic [SLOT_W-1:0] slot_free;
    logic              adj;
    logic [30:0]       max;
  } tok_t;

  typedef struct packed {
    logic              pass2;
    logic [31:0]       id_a;
    logic [31:0]       id_b;
    logic [SLOT_W-1:0] slot_s;
    logic [SLOT_W-1:0] slot_d;
  } bcast_t;

  typedef struct packed {
    logic              en;
    logic [1:0]        op;
    logic [SLOT_W-1:0] x;
    logic [SLOT_W-1:0] y;
    logic [31:0]       id;
  } cmd_t;

endpackage

@@ hdl/adjmg_cell.sv @@
// One vertex slot: id, valid bit and adjacency row, plus one stage of the scan token.
// Depends on adjmg_pkg.
module adjmg_cell import adjmg_pkg::*; #(
  parameter int unsigned MaxVertices = 64,
  parameter int unsigned Index       = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  bcast_t bc_i,
  input  cmd_t   cmd_i,
  input  tok_t   tok_i,
  output tok_t   tok_o
);

  localparam int unsigned SlotW = $clog2(MaxVertices);
  localparam logic [SLOT_W-1:0] MyIdx = SLOT_W'(Index);

  logic                   valid_q, valid_d;
  logic [31:0]            id_q;
  logic [MaxVertices-1:0] row_q, row_d;
  tok_t                   tok_q, tok_d;
  logic                   edge_val;

  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld) begin
      if (!bc_i.pass2) begin
        if (valid_q && id_q == bc_i.id_a && !tok_i.found_a) begin
          tok_d.found_a = 1'b1;
          tok_d.slot_a  = MyIdx;
        end
        if (valid_q && id_q == bc_i.id_b && !tok_i.found_b) begin
          tok_d.found_b = 1'b1;
          tok_d.slot_b  = MyIdx;
        end
        if (!valid_q && !tok_i.free_ok) begin
          tok_d.free_ok   = 1'b1;
          tok_d.slot_free = MyIdx;
        end
      end else begin
        if (MyIdx == bc_i.slot_s) begin
          tok_d.adj = row_q[bc_i.slot_d[SlotW-1:0]];
        end
        if (MyIdx != bc_i.slot_s && valid_q && row_q[bc_i.slot_s[SlotW-1:0]] &&
            !id_q[31] && id_q[30:0] > tok_i.max) begin
          tok_d.max = id_q[30:0];
        end
      end
    end
  end

  always_comb begin
    row_d    = row_q;
    valid_d  = valid_q;
    edge_val = (cmd_i.op == CMD_SET_E);
    if (cmd_i.en) begin
      unique case (cmd_i.op) inside
        CMD_ADD_V, CMD_DEL_V: begin
          row_d[cmd_i.x[SlotW-1:0]] = 1'b0;
          if (MyIdx == cmd_i.x) begin
            row_d   = '0;
            valid_d = (cmd_i.op == CMD_ADD_V);
          end
        end
        CMD_SET_E, CMD_CLR_E: begin
          if (MyIdx == cmd_i.x) row_d[cmd_i.y[SlotW-1:0]] = edge_val;
          if (MyIdx == cmd_i.y) row_d[cmd_i.x[SlotW-1:0]] = edge_val;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      row_q   <= '0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      row_q   <= row_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.en && cmd_i.op == CMD_ADD_V && MyIdx == cmd_i.x) begin
      id_q <= cmd_i.id;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ hdl/adjacency_matrix_graph_table.sv @@
// Top level of the adjacency-matrix graph table: sequencer, output register, cell chain.
// Depends on adjmg_pkg and adjmg_cell.
//
//   port        dir  word        handshake
//   in_data_i   in   in_word_t   in_valid_i / in_ready_o
//   out_data_o  out  out_word_t  out_valid_o / out_ready_i
//
// A scan token walks the cell chain one slot per cycle. Vertex add/remove and
// unknown endpoints finish after the first pass; edge ops and queries with known
// vertices take a second pass.
// Reset clears all valid bits and adjacency rows at once; no clearing pass.
// A waiting result does not block the next word; only a second result stalls.
module adjacency_matrix_graph_table import adjmg_pkg::*; #(
  parameter int unsigned MaxVertices = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN1 = 2'd1;
  localparam logic [1:0] S_SCAN2 = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic              inj_q, inj_d;
  logic [2:0]        func_q;
  logic [31:0]       a_q, b_q;
  logic [SLOT_W-1:0] s_q, s_d, d_q, d_d;
  out_word_t         res_q, res_d;
  cmd_t              cmd_q, cmd_d;
  logic              out_vld_q;
  out_word_t         out_q;
  bcast_t            bc;
  tok_t              tok [MaxVertices+1];
  tok_t              tok_end;
  logic              accept;
  logic              out_load;

  assign accept   = in_valid_i && in_ready_o;
  assign out_load = (state_q == S_OUT) && (!out_vld_q || out_ready_i);
  assign tok_end  = tok[MaxVertices];

  always_comb begin
    tok[0]     = '0;
    tok[0].vld = inj_q;
  end

  assign bc.pass2  = (state_q == S_SCAN2);
  assign bc.id_a   = a_q;
  assign bc.id_b   = b_q;
  assign bc.slot_s = s_q;
  assign bc.slot_d = d_q;

  for (genvar g = 0; g < MaxVertices; g++) begin : g_cell
    adjmg_cell #(
      .MaxVertices(MaxVertices),
      .Index      (g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .bc_i  (bc),
      .cmd_i (cmd_q),
      .tok_i (tok[g]),
      .tok_o (tok[g+1])
    );
  end

  always_comb begin
    state_d = state_q;
    inj_d   = 1'b0;
    cmd_d   = '0;
    res_d   = res_q;
    s_d     = s_q;
    d_d     = d_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          inj_d   = 1'b1;
          state_d = S_SCAN1;
        end
      end
      S_SCAN1: begin
        if (tok_end.vld) begin
          s_d     = tok_end.slot_a;
          d_d     = tok_end.slot_b;
          res_d   = '0;
          state_d = S_OUT;
          unique case (func_q)
            FN_ADD_V: begin
              if (!tok_end.found_a) begin
                if (tok_end.free_ok) begin
                  cmd_d.en = 1'b1;
                  cmd_d.op = CMD_ADD_V;
                  cmd_d.x  = tok_end.slot_free;
                  cmd_d.id = a_q;
                end else begin
                  res_d.status = STAT_FULL;
                end
              end
            end
            FN_DEL_V: begin
              if (tok_end.found_a) begin
                cmd_d.en = 1'b1;
                cmd_d.op = CMD_DEL_V;
                cmd_d.x  = tok_end.slot_a;
              end
            end
            FN_ADD_E, FN_DEL_E: begin
              if (tok_end.found_a && tok_end.found_b) begin
                inj_d   = 1'b1;
                state_d = S_SCAN2;
              end
            end
            FN_QUERY: begin
              if (tok_end.found_a) begin
                inj_d   = 1'b1;
                state_d = S_SCAN2;
              end else begin
                res_d.status = STAT_NONE;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN2: begin
        if (tok_end.vld) begin
          state_d = S_OUT;
          unique case (func_q)
            FN_ADD_E: begin
              if (tok_end.adj) begin
                res_d.status = STAT_EXISTS;
              end else begin
                cmd_d.en = 1'b1;
                cmd_d.op = CMD_SET_E;
                cmd_d.x  = s_q;
                cmd_d.y  = d_q;
              end
            end
            FN_DEL_E: begin
              if (!tok_end.adj) begin
                res_d.status = STAT_NONE;
              end else begin
                cmd_d.en = 1'b1;
                cmd_d.op = CMD_CLR_E;
                cmd_d.x  = s_q;
                cmd_d.y  = d_q;
              end
            end
            FN_QUERY: begin
              if (tok_end.max == '0) begin
                res_d.status = STAT_NONE;
              end else begin
                res_d.status        = STAT_MAX;
                res_d.max_neighbour = tok_end.max;
              end
            end
            default: ;
          endcase
        end
      end
      S_OUT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      inj_q     <= 1'b0;
      cmd_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      inj_q   <= inj_d;
      cmd_q   <= cmd_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= in_data_i.func;
      a_q    <= in_data_i.vertex_a;
      b_q    <= in_data_i.vertex_b;
    end
    s_q   <= s_d;
    d_q   <= d_d;
    res_q <= res_d;
    if (out_load) out_q <= res_q;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

@@ tb/tb_adjacency_matrix_graph_table.sv @@
// Testbench for the adjacency-matrix graph table: directed and random words checked
// against a behavioral graph store. Depends on adjmg_pkg and adjacency_matrix_graph_table.
`timescale 1ns / 100ps

module tb_adjacency_matrix_graph_table;
  import adjmg_pkg::*;

  localparam int NV = 64;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;

  adjacency_matrix_graph_table #(.MaxVertices(NV)) u_dut (.*);

  initial forever #1 clk_i = ~clk_i;

  logic [31:0]   graph_ids [NV];
  logic          graph_used [NV];
  logic [NV-1:0] graph_adj [NV];
  out_word_t     pending_results [$];
  int            mismatch_count = 0;
  bit            sink_stall_on = 1'b1;
  logic [31:0]   id_pool [16];

  function automatic int slot_of(logic [31:0] id);
    for (int i = 0; i < NV; i++) if (graph_used[i] && graph_ids[i] == id) return i;
    return -1;
  endfunction

  function automatic out_word_t graph_apply(in_word_t w);
    out_word_t r;
    int s, d;
    logic [30:0] m;
    r = '0;
    s = slot_of(w.vertex_a);
    d = slot_of(w.vertex_b);
    case (w.func)
      FN_ADD_V: begin
        if (s < 0) begin
          r.status = STAT_FULL;
          for (int i = 0; i < NV; i++) if (!graph_used[i]) begin
            graph_ids[i] = w.vertex_a;
            graph_used[i] = 1'b1;
            graph_adj[i] = '0;
            for (int k = 0; k < NV; k++) graph_adj[k][i] = 1'b0;
            r.status = STAT_DONE;
            break;
          end
        end
      end
      FN_DEL_V: begin
        if (s >= 0) begin
          graph_adj[s] = '0;
          for (int k = 0; k < NV; k++) graph_adj[k][s] = 1'b0;
          graph_used[s] = 1'b0;
        end
      end
      FN_ADD_E: begin
        if (s >= 0 && d >= 0) begin
          if (graph_adj[s][d] || graph_adj[d][s]) r.status = STAT_EXISTS;
          else begin
            graph_adj[s][d] = 1'b1;
            graph_adj[d][s] = 1'b1;
          end
        end
      end
      FN_DEL_E: begin
        if (s >= 0 && d >= 0) begin
          if (!graph_adj[s][d] || !graph_adj[d][s]) r.status = STAT_NONE;
          else begin
            graph_adj[s][d] = 1'b0;
            graph_adj[d][s] = 1'b0;
          end
        end
      end
      FN_QUERY: begin
        m = '0;
        if (s >= 0)
          for (int k = 0; k < NV; k++)
            if (k != s && graph_used[k] && graph_adj[s][k] && !graph_ids[k][31]
                && graph_ids[k][30:0] > m) m = graph_ids[k][30:0];
        if (m == 0) r.status = STAT_NONE;
        else begin
          r.status = STAT_MAX;
          r.max_neighbour = m;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  task automatic report_mismatch(string what, out_word_t got, out_word_t want);
    $display("mismatch %s: got status %0d max %0d, want status %0d max %0d", what,
             got.status, got.max_neighbour, want.status, want.max_neighbour);
    mismatch_count++;
  endtask

  task automatic send_word(logic [2:0] fn, logic [31:0] a, logic [31:0] b);
    in_word_t  w;
    out_word_t want_w;
    int        gap;
    w.func = fn;
    w.vertex_a = a;
    w.vertex_b = b;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    want_w = graph_apply(w);
    pending_results.insert(pending_results.size(), want_w);
  endtask

  // sink: random stall, check each word against the oldest expectation
  initial begin
    out_word_t want;
    int        hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word", out_data_o, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.status !== want.status) report_mismatch("status", out_data_o, want);
          else if (out_data_o.max_neighbour !== want.max_neighbour)
            report_mismatch("max_neighbour", out_data_o, want);
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else if (sink_stall_on && $urandom_range(0, 99) < 3) begin
        hold_cnt = $urandom_range(10, 150);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= sink_stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
    end
  end

  function automatic logic [31:0] pick_id();
    int p;
    p = $urandom_range(0, 9);
    if (p < 7) return id_pool[$urandom_range(0, 15)];
    if (p < 8) return $urandom();
    return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'd0} | 32'($urandom_range(0, 3));
  endfunction

  task automatic test_directed();
    send_word(FN_QUERY, 32'd5, 32'd0);
    send_word(FN_ADD_V, 32'd5, 32'd0);
    send_word(FN_ADD_V, 32'd5, 32'd0);
    send_word(FN_ADD_V, 32'h7fffffff, 32'd0);
    send_word(FN_ADD_V, 32'h80000000, 32'd0);
    send_word(FN_ADD_V, 32'hffffffff, 32'd0);
    send_word(FN_ADD_V, 32'd0, 32'd0);
    send_word(FN_QUERY, 32'd5, 32'd0);
    send_word(FN_ADD_E, 32'd5, 32'h80000000);
    send_word(FN_ADD_E, 32'd5, 32'd0);
    send_word(FN_ADD_E, 32'd5, 32'd5);
    send_word(FN_QUERY, 32'd5, 32'd0);
    send_word(FN_ADD_E, 32'd5, 32'h7fffffff);
    send_word(FN_ADD_E, 32'h7fffffff, 32'd5);
    send_word(FN_QUERY, 32'd5, 32'd0);
    send_word(FN_ADD_E, 32'd5, 32'd99);
    send_word(FN_DEL_E, 32'd5, 32'hffffffff);
    send_word(FN_DEL_E, 32'd5, 32'd99);
    send_word(FN_DEL_E, 32'd5, 32'h7fffffff);
    send_word(FN_DEL_V, 32'd77, 32'd0);
    send_word(FN_DEL_V, 32'h7fffffff, 32'd0);
    send_word(3'd5, 32'd5, 32'd5);
    send_word(3'd6, 32'hffffffff, 32'hffffffff);
    send_word(3'd7, 32'd0, 32'h7fffffff);
    send_word(FN_QUERY, 32'd5, 32'd0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < NV + 2; i++) send_word(FN_ADD_V, 32'd1000 + i, 32'd0);
    send_word(FN_ADD_E, 32'd1000, 32'd1063);
    send_word(FN_QUERY, 32'd1063, 32'd0);
    for (int i = 0; i < NV; i++) send_word(FN_DEL_V, 32'd1000 + i, 32'd0);
    send_word(FN_DEL_V, 32'd5, 32'd0);
    send_word(FN_DEL_V, 32'h80000000, 32'd0);
    send_word(FN_DEL_V, 32'hffffffff, 32'd0);
    send_word(FN_DEL_V, 32'd0, 32'd0);
  endtask

  task automatic test_random(int n);
    logic [2:0] fn;
    int p;
    for (int i = 0; i < 16; i++) id_pool[i] = (i < 12) ? 32'($urandom_range(1, 4000)) : $urandom();
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) sink_stall_on = 1'b0;
      if (i == n / 2 + 60) sink_stall_on = 1'b1;
      p = $urandom_range(0, 99);
      if (p < 25) fn = FN_ADD_V;
      else if (p < 35) fn = FN_DEL_V;
      else if (p < 60) fn = FN_ADD_E;
      else if (p < 75) fn = FN_DEL_E;
      else if (p < 97) fn = FN_QUERY;
      else fn = 3'($urandom_range(5, 7));
      send_word(fn, pick_id(), pick_id());
    end
  endtask

  initial begin
    int guard;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_random(480);
    in_valid_i <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (300) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    for (int i = 0; i < NV; i++) begin
      graph_used[i] = 1'b0;
      graph_ids[i] = '0;
      graph_adj[i] = '0;
    end
  end

endmodule
